[hw/rtl/selective_repeat_sender_window_defines.svh]
// ---------------------------------------------------------------------------
// Selective-repeat sender window: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRSW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRSW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/srsw_pkg.sv]
// ---------------------------------------------------------------------------
// Selective-repeat sender window: shared package
// Field widths, command codes and the packed word types of both channels.
// ---------------------------------------------------------------------------
package srsw_pkg;

    // Fixed field widths.
    localparam int SEQ_BITS       = 16;
    localparam int PAYLOAD_BITS   = 64;
    localparam int TIMEOUT_BITS   = 16;
    localparam int WINDOW_DEFAULT = 8;

    typedef logic [SEQ_BITS-1:0]     t_seq;
    typedef logic [PAYLOAD_BITS-1:0] t_payload;
    typedef logic [TIMEOUT_BITS-1:0] t_timeout;
    typedef logic [1:0]              t_cmd;

    // Timer period after reset.
    localparam t_timeout TIMEOUT_RESET = 16'd20;

    // Command codes; the fourth code is accepted and ignored.
    localparam t_cmd CMD_SEND   = 2'd0;
    localparam t_cmd CMD_ACK    = 2'd1;
    localparam t_cmd CMD_EXPIRE = 2'd2;

    // Input word.
    typedef struct packed {
        t_cmd     command;
        t_payload payload;
        t_seq     sequence_number;
        logic     checksum_ok;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic     send_accepted;
        logic     packet_out;
        t_seq     packet_seq;
        t_payload packet_payload;
        logic     start_timer;
        logic     stop_timer;
        t_seq     timer_seq;
        t_timeout timer_length;
        logic     window_full;
        t_seq     base_seq;
        t_seq     next_seq;
        logic     ignored;
    } t_out_word;

endpackage

[hw/rtl/srsw_payload_ram.sv]
// ---------------------------------------------------------------------------
// Selective-repeat sender window: payload store
// Single-port synchronous memory holding one payload per window slot, with
// registered read data. Contents are not cleared by reset.
// ---------------------------------------------------------------------------
module srsw_payload_ram #(
    parameter int DEPTH = srsw_pkg::WINDOW_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  srsw_pkg::t_payload       i_wdata,
    output srsw_pkg::t_payload       o_rdata
);
    import srsw_pkg::*;

    t_payload r_mem [DEPTH];
    t_payload r_rdata;

    // Write or read one entry per enabled cycle; read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/selective_repeat_sender_window.sv]
// An input word is registered at acceptance and executed in S_EXEC; its result
// goes to the output register once the output is free, after S_SLIDE has retired
// the leading acked entries on an ack of the base. The input stalls until the
// result is posted, so a new word is taken only when the last is done; the base
// slide retires one entry per cycle. Reset is synchronous, active low: counters
// and ack flags clear, timeout takes TIMEOUT_RESET; payload memory is not cleared.
// ---------------------------------------------------------------------------
// Selective-repeat sender window
// Sender side of selective-repeat ARQ: stores payloads under sequence
// numbers, re-emits them on timer expiry and slides the base on acks.
// ---------------------------------------------------------------------------
`include "selective_repeat_sender_window_defines.svh"

module selective_repeat_sender_window #(
    parameter int WINDOW = srsw_pkg::WINDOW_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration port.
    input  logic                i_cfg_we,
    input  srsw_pkg::t_timeout  i_cfg_data,
    // Input channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  srsw_pkg::t_in_word  i_in_word,
    // Output channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output srsw_pkg::t_out_word o_out_word
);
    import srsw_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam logic [SLOT_W:0]   WIN_S     = (SLOT_W + 1)'(WINDOW);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  WIN_C     = CNT_W'(WINDOW);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_SLIDE = 3'b100
    } t_state;

    // Window state.
    t_state            r_state, n_state;
    t_seq              r_base, n_base;
    t_seq              r_next, n_next;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [WINDOW-1:0] r_acked, n_acked;
    t_timeout          r_timeout;

    // Decoded word held between acceptance and execution.
    t_cmd              r_cmd;
    t_payload          r_pay;
    t_seq              r_seq;
    logic              r_hit;
    logic              r_off0;
    logic              r_send_ok;
    logic [SLOT_W-1:0] r_slot;

    // Result staging and output register.
    t_out_word         r_res, n_res;
    t_out_word         r_out_word, n_out_word;
    logic              r_out_valid;
    logic              load_out;

    logic              in_accept;
    logic              out_free;
    t_seq              off;
    logic              in_win;
    logic              send_ok;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] send_slot;
    logic [SLOT_W-1:0] acc_slot;
    logic              ram_en;
    t_payload          ram_rdata;
    t_out_word         exec_res;
    logic              exec_slide;

    // Slot arithmetic modulo the window size; both operands lie below it.
    function automatic logic [SLOT_W-1:0] f_wrap(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= WIN_S) begin
            sum = sum - WIN_S;
        end
        return sum[SLOT_W-1:0];
    endfunction

    // Handshakes.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Window tests on the incoming word, against state that holds until it is done.
    assign off       = i_in_word.sequence_number - r_base;
    assign in_win    = (off < t_seq'(r_count));
    assign send_ok   = (r_count < WIN_C);
    assign hit_slot  = f_wrap(r_head, off[SLOT_W-1:0]);
    assign send_slot = f_wrap(r_head, r_count[SLOT_W-1:0]);
    assign acc_slot  = (i_in_word.command == CMD_SEND) ? send_slot : hit_slot;
    assign ram_en    = in_accept && (((i_in_word.command == CMD_SEND) && send_ok) ||
                                     ((i_in_word.command == CMD_EXPIRE) && in_win));

    // Payload memory: a send writes at acceptance, an expiry reads at acceptance.
    srsw_payload_ram #(
        .DEPTH (WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (i_in_word.command == CMD_SEND),
        .i_addr  (acc_slot),
        .i_wdata (i_in_word.payload),
        .o_rdata (ram_rdata)
    );

    // Capture the decoded word.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd     <= i_in_word.command;
            r_pay     <= i_in_word.payload;
            r_seq     <= i_in_word.sequence_number;
            r_hit     <= (i_in_word.command == CMD_ACK) ? (in_win && i_in_word.checksum_ok)
                                                        : in_win;
            r_off0    <= (off == '0);
            r_send_ok <= send_ok;
            r_slot    <= acc_slot;
        end
    end

    // Result of the command itself, before the window status fields.
    always_comb begin
        exec_res   = '0;
        exec_slide = 1'b0;
        unique case (r_cmd)
            CMD_SEND: begin
                if (r_send_ok) begin
                    exec_res.send_accepted  = 1'b1;
                    exec_res.packet_out     = 1'b1;
                    exec_res.packet_seq     = r_next;
                    exec_res.packet_payload = r_pay;
                    exec_res.start_timer    = 1'b1;
                    exec_res.timer_seq      = r_next;
                    exec_res.timer_length   = r_timeout;
                end
            end
            CMD_ACK: begin
                if (r_hit) begin
                    exec_res.stop_timer = 1'b1;
                    exec_res.timer_seq  = r_seq;
                    exec_slide          = r_off0;
                end else begin
                    exec_res.ignored = 1'b1;
                end
            end
            CMD_EXPIRE: begin
                if (r_hit) begin
                    exec_res.packet_out     = 1'b1;
                    exec_res.packet_seq     = r_seq;
                    exec_res.packet_payload = ram_rdata;
                    exec_res.start_timer    = 1'b1;
                    exec_res.timer_seq      = r_seq;
                    exec_res.timer_length   = r_timeout;
                end else begin
                    exec_res.ignored = 1'b1;
                end
            end
            default: begin
                exec_res.ignored = 1'b1;
            end
        endcase
    end

    // Sequencer: execute, slide the base one entry a cycle, then post the result.
    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_next     = r_next;
        n_count    = r_count;
        n_head     = r_head;
        n_acked    = r_acked;
        n_res      = r_res;
        n_out_word = r_res;
        load_out   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    if ((r_cmd == CMD_SEND) && r_send_ok) begin
                        n_next          = r_next + 1'b1;
                        n_count         = r_count + 1'b1;
                        n_acked[r_slot] = 1'b0;
                    end
                    if ((r_cmd == CMD_ACK) && r_hit) begin
                        n_acked[r_slot] = 1'b1;
                    end
                    if (exec_slide) begin
                        n_res   = exec_res;
                        n_state = S_SLIDE;
                    end else begin
                        n_out_word = exec_res;
                        load_out   = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_SLIDE: begin
                if ((r_count != '0) && r_acked[r_head]) begin
                    n_acked[r_head] = 1'b0;
                    n_head          = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                    n_base          = r_base + 1'b1;
                    n_count         = r_count - 1'b1;
                end else if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // Window status after this word.
        n_out_word.window_full = (n_count == WIN_C);
        n_out_word.base_seq    = n_base;
        n_out_word.next_seq    = n_next;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_next      <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_acked     <= '0;
            r_timeout   <= TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_next  <= n_next;
            r_count <= n_count;
            r_head  <= n_head;
            r_acked <= n_acked;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result staging and output word.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (load_out) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Checks.
    `SRSW_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= WIN_C,
                     "outstanding count above window")
    `SRSW_ASSERT_IMP(a_count_match, i_clk, i_rst_n, 1'b1,
                     t_seq'(r_next - r_base) == t_seq'(r_count),
                     "count disagrees with sequence numbers")
    `SRSW_ASSERT_IMP(a_stop_alone, i_clk, i_rst_n, o_out_valid && o_out_word.stop_timer,
                     !o_out_word.packet_out && !o_out_word.ignored,
                     "stop request with packet or ignore")
    `SRSW_ASSERT_NXT(a_slide_ends, i_clk, i_rst_n,
                     (r_state == S_SLIDE) && (r_count == '0) && out_free,
                     r_state == S_IDLE, "slide did not finish on empty window")

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Selective-repeat sender window: self-checking testbench
// Drives send, acknowledgement and expiry words into the window and keeps a
// behavioural copy of the window state. Every result word is checked field by
// field against the copy. The run covers directed corner cases, the store
// slots wrapping round several times, a long receiver hold-off and random
// traffic under several idling mixes and timeout settings.
// ---------------------------------------------------------------------------
module tb;
    import srsw_pkg::*;

    localparam int   WINDOW         = WINDOW_DEFAULT;
    localparam int   DRAIN_CYCLES   = 20;
    localparam int   HOLD_CYCLES    = 500;
    localparam int   WATCHDOG_LIMIT = 4000;
    // The fourth command code has no name in the package; the block ignores it.
    localparam t_cmd CMD_SPARE      = 2'd3;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_cfg_we   = 1'b0;
    t_timeout  i_cfg_data = '0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word  = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    selective_repeat_sender_window #(
        .WINDOW(WINDOW)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    // Behavioural copy of the window state.
    t_payload win_payload [WINDOW];
    logic     win_acked   [WINDOW];
    t_seq     win_base;
    t_seq     win_next;
    int       win_head;
    t_timeout win_timeout;

    t_out_word expected_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int fail_count     = 0;
    int words_sent     = 0;
    int useful_words   = 0;
    int results_checked = 0;
    int timeouts_set   = 0;

    // Clock generation.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Store slot of the entry at a given offset from the base.
    function automatic int slot_at(input t_seq off);
        return (win_head + int'(off)) % WINDOW;
    endfunction

    // Advances the window copy by one word and returns the result it should give.
    function automatic t_out_word predict_window(input t_in_word w);
        t_out_word r;
        t_seq      count;
        t_seq      off;
        int        s;
        r     = '0;
        count = win_next - win_base;
        off   = w.sequence_number - win_base;
        case (w.command)
            CMD_SEND: begin
                if (count < WINDOW) begin
                    s              = slot_at(count);
                    win_payload[s] = w.payload;
                    win_acked[s]   = 1'b0;
                    r.send_accepted  = 1'b1;
                    r.packet_out     = 1'b1;
                    r.packet_seq     = win_next;
                    r.packet_payload = w.payload;
                    r.start_timer    = 1'b1;
                    r.timer_seq      = win_next;
                    r.timer_length   = win_timeout;
                    win_next         = win_next + 1'b1;
                end
            end
            CMD_ACK: begin
                if (count == 0 || !w.checksum_ok || off >= count) begin
                    r.ignored = 1'b1;
                end else begin
                    r.stop_timer = 1'b1;
                    r.timer_seq  = w.sequence_number;
                    win_acked[slot_at(off)] = 1'b1;
                    // An ack on the base slides it past every leading acked entry.
                    if (off == 0) begin
                        while (count > 0 && win_acked[win_head]) begin
                            win_acked[win_head] = 1'b0;
                            win_head = (win_head + 1) % WINDOW;
                            win_base = win_base + 1'b1;
                            count    = count - 1'b1;
                        end
                    end
                end
            end
            CMD_EXPIRE: begin
                if (off >= count) begin
                    r.ignored = 1'b1;
                end else begin
                    r.packet_out     = 1'b1;
                    r.packet_seq     = w.sequence_number;
                    r.packet_payload = win_payload[slot_at(off)];
                    r.start_timer    = 1'b1;
                    r.timer_seq      = w.sequence_number;
                    r.timer_length   = win_timeout;
                end
            end
            default: begin
                r.ignored = 1'b1;
            end
        endcase
        r.window_full = (t_seq'(win_next - win_base) >= WINDOW);
        r.base_seq    = win_base;
        r.next_seq    = win_next;
        return r;
    endfunction

    function automatic t_in_word make_word(input t_cmd c, input t_payload p,
                                           input t_seq s, input logic ck);
        t_in_word w;
        w.command         = c;
        w.payload         = p;
        w.sequence_number = s;
        w.checksum_ok     = ck;
        return w;
    endfunction

    // Offers one word, waits for it to be taken, records its expected result
    // and then idles for a random gap.
    task automatic send_word(input t_in_word w);
        t_out_word want;
        int        gap;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = predict_window(w);
        expected_results.push_back(want);
        words_sent++;
        if (!want.ignored && !(w.command == CMD_SEND && !want.send_accepted))
            useful_words++;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Lets every outstanding result arrive and the block settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_timeout(input t_timeout value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        win_timeout = value;
        timeouts_set++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input t_out_word got);
        t_out_word want;
        if (expected_results.size() == 0) begin
            $error("result word 0x%0h arrived with nothing expected", got);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        compare_field("send_accepted",  want.send_accepted,  got.send_accepted);
        compare_field("packet_out",     want.packet_out,     got.packet_out);
        compare_field("packet_seq",     want.packet_seq,     got.packet_seq);
        compare_field("packet_payload", want.packet_payload, got.packet_payload);
        compare_field("start_timer",    want.start_timer,    got.start_timer);
        compare_field("stop_timer",     want.stop_timer,     got.stop_timer);
        compare_field("timer_seq",      want.timer_seq,      got.timer_seq);
        compare_field("timer_length",   want.timer_length,   got.timer_length);
        compare_field("window_full",    want.window_full,    got.window_full);
        compare_field("base_seq",       want.base_seq,       got.base_seq);
        compare_field("next_seq",       want.next_seq,       got.next_seq);
        compare_field("ignored",        want.ignored,        got.ignored);
    endtask

    // Receiver: checks each accepted result word, then chooses the next stall.
    // A hold-off request keeps the stall high for a counted stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) check_result(o_out_word);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Picks a random word, mostly well-formed traffic against the current window.
    function automatic t_in_word pick_random_word();
        int unsigned roll;
        t_seq        count;
        t_in_word    w;
        roll  = $urandom_range(0, 99);
        count = win_next - win_base;
        w = make_word(CMD_SEND, {$urandom, $urandom}, t_seq'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)));
        if (roll < 40) begin
            // Random payload is already in place; now and then an extreme one.
            if ($urandom_range(0, 19) == 0) w.payload = '1;
            else if ($urandom_range(0, 19) == 0) w.payload = '0;
        end else if (roll < 65 && count != 0) begin
            w.command         = CMD_ACK;
            w.sequence_number = win_base + t_seq'($urandom_range(0, count - 1));
            w.checksum_ok     = ($urandom_range(0, 19) != 0);
        end else if (roll < 75 && count != 0) begin
            w.command         = CMD_ACK;
            w.sequence_number = win_base;
            w.checksum_ok     = 1'b1;
        end else if (roll < 85 && count != 0) begin
            w.command         = CMD_EXPIRE;
            w.sequence_number = win_base + t_seq'($urandom_range(0, count - 1));
        end else if (roll < 92) begin
            w.command = CMD_ACK;
        end else if (roll < 97) begin
            w.command = CMD_EXPIRE;
        end else begin
            w.command = CMD_SPARE;
        end
        return w;
    endfunction

    // Empty window, spare code, filling, refusal, bad acks, repeats and a slide.
    task automatic test_directed_cases();
        int k;
        send_word(make_word(CMD_ACK,    '0, 16'd0,    1'b1));
        send_word(make_word(CMD_EXPIRE, '0, 16'd0,    1'b0));
        send_word(make_word(CMD_SPARE,  '1, 16'hFFFF, 1'b1));
        send_word(make_word(CMD_SEND,   '0, 16'hFFFF, 1'b0));
        send_word(make_word(CMD_SEND,   '1, 16'd0,    1'b1));
        for (k = 0; k < WINDOW - 2; k++)
            send_word(make_word(CMD_SEND, {$urandom, $urandom}, 16'd0, 1'b0));
        // The window is full now, so this send must be refused.
        send_word(make_word(CMD_SEND,   '1, 16'd5,    1'b1));
        send_word(make_word(CMD_ACK,    '0, 16'd3,    1'b0));
        send_word(make_word(CMD_ACK,    '0, 16'd8,    1'b1));
        send_word(make_word(CMD_ACK,    '0, 16'hFFFF, 1'b1));
        send_word(make_word(CMD_ACK,    '0, 16'd2,    1'b1));
        send_word(make_word(CMD_ACK,    '1, 16'd2,    1'b1));
        send_word(make_word(CMD_EXPIRE, '0, 16'd1,    1'b0));
        send_word(make_word(CMD_EXPIRE, '0, 16'd8,    1'b1));
        send_word(make_word(CMD_ACK,    '0, 16'd1,    1'b1));
        // Acking the base retires entries 0, 1 and 2 in one go.
        send_word(make_word(CMD_ACK,    '0, 16'd0,    1'b1));
        send_word(make_word(CMD_EXPIRE, '0, 16'd0,    1'b1));
        send_word(make_word(CMD_SEND,   {$urandom, $urandom}, 16'd0, 1'b0));
        send_word(make_word(CMD_EXPIRE, '0, 16'd7,    1'b0));
    endtask

    // Keeps a few packets in flight while the base walks several times round
    // the store, so that the slot numbers wrap under sends, acks and expiries.
    task automatic test_slot_wrap();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (k = 0; k < 12 * WINDOW; k++) begin
            if (t_seq'(win_next - win_base) < 3)
                send_word(make_word(CMD_SEND, {$urandom, $urandom}, 16'd0, 1'b0));
            else if (k % 5 == 0)
                send_word(make_word(CMD_EXPIRE, '0, win_base + 16'd1, 1'b0));
            else
                send_word(make_word(CMD_ACK, '0, win_base, 1'b1));
        end
    endtask

    // Holds the receiver off for a long stretch while words keep coming, so
    // the block backs up and stalls its input.
    task automatic test_receiver_hold();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLD_CYCLES;
        for (k = 0; k < 40; k++) send_word(pick_random_word());
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int target);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start          = useful_words;
        while (useful_words - start < target) send_word(pick_random_word());
    endtask

    initial begin
        for (int k = 0; k < WINDOW; k++) begin
            win_payload[k] = '0;
            win_acked[k]   = 1'b0;
        end
        win_base    = '0;
        win_next    = '0;
        win_head    = 0;
        win_timeout = TIMEOUT_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        set_timeout(16'd1);
        test_slot_wrap();
        set_timeout(16'hFFFF);
        test_receiver_hold();
        set_timeout(t_timeout'($urandom_range(1, 65535)));
        test_random_traffic(0, 0, 180);
        set_timeout(t_timeout'($urandom_range(1, 65535)));
        test_random_traffic(55, 0, 180);
        set_timeout(16'd1);
        test_random_traffic(0, 55, 180);
        set_timeout(TIMEOUT_RESET);
        test_random_traffic(6, 6, 180);
        drain_results();

        $display("Covered %0d input words and %0d checked results under %0d timeout settings,",
                 words_sent, results_checked, timeouts_set);
        $display("with store slots wrapping, a %0d-cycle receiver hold-off and four idling mixes.",
                 HOLD_CYCLES);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/srsw_pkg.sv
hw/rtl/srsw_payload_ram.sv
hw/rtl/selective_repeat_sender_window.sv
sim/tb.sv
